[design/assert_macros.svh]
// assert_macros.svh: assertion macros used by the checker file.
// Relies on clk and rst_n in the scope where the macros are used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is asserted
`define MRPE_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mrpe assertion failed");

// next-cycle implication, off while reset is asserted
`define MRPE_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mrpe assertion failed");

`endif

[design/mrpe_pkg.sv]
// mrpe_pkg: item types, relocation codes and masks of the relocation patch engine.
// No dependencies.
package mrpe_pkg;

    typedef struct packed {
        logic        req_type;
        logic [7:0]  reloc_type;
        logic [31:0] target_address;
        logic [31:0] symbol_value;
        logic [31:0] addend;
        logic [31:0] current_word;
        logic        symbol_missing;
    } request_t;

    typedef struct packed {
        logic [31:0] write_address;
        logic [31:0] write_data;
        logic [1:0]  status;
        logic        last;
    } result_t;

    // one pending HI16 entry as kept in the queue memory
    typedef struct packed {
        logic [31:0] address;
        logic [31:0] value;
        logic [31:0] word;
    } entry_t;

    localparam logic [1:0] STATUS_PATCH      = 2'd0;
    localparam logic [1:0] STATUS_UNRESOLVED = 2'd1;
    localparam logic [1:0] STATUS_BAD_TYPE   = 2'd2;

    localparam logic [7:0] RELOC_WORD32 = 8'd2;
    localparam logic [7:0] RELOC_JUMP26 = 8'd4;
    localparam logic [7:0] RELOC_HI16   = 8'd5;
    localparam logic [7:0] RELOC_LO16   = 8'd6;

    localparam logic [31:0] JUMP_KEEP_MASK  = 32'hFC000000;
    localparam logic [31:0] JUMP_FIELD_MASK = 32'h03FFFFFF;

    typedef enum logic [3:0] {
        ACT_CLEAR = 4'b0001,
        ACT_EMIT  = 4'b0010,
        ACT_QUEUE = 4'b0100,
        ACT_WALK  = 4'b1000
    } action_t;

    typedef struct packed {
        action_t     action;
        result_t     result;
        entry_t      entry;
        logic [15:0] hi;
    } decode_t;

endpackage

[design/mrpe_ram.sv]
// mrpe_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module mrpe_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[design/mrpe_decode.sv]
// mrpe_decode: classifies one request and computes the relocation value and patch words.
// Depends on mrpe_pkg.
module mrpe_decode
    import mrpe_pkg::*;
(
    input  request_t request,
    output decode_t  dec
);

    logic [31:0] value;
    logic [31:0] slo;
    logic [31:0] hi_diff;

    assign value   = request.symbol_value + request.addend;
    assign slo     = {{16{value[15]}}, value[15:0]};
    assign hi_diff = value - slo;

    always_comb
    begin
        dec.entry.address          = request.target_address;
        dec.entry.value            = value;
        dec.entry.word             = request.current_word;
        dec.hi                     = hi_diff[31:16];
        dec.result.write_address   = request.target_address;
        dec.result.write_data      = '0;
        dec.result.status          = STATUS_PATCH;
        dec.result.last            = 1'b1;
        dec.action                 = ACT_EMIT;
        if (request.req_type)
        begin
            dec.action = ACT_CLEAR;
        end
        else if (request.symbol_missing)
        begin
            dec.result.status = STATUS_UNRESOLVED;
        end
        else
        begin
            unique case (request.reloc_type)
                RELOC_WORD32:
                begin
                    dec.result.write_data = request.current_word + value;
                end
                RELOC_JUMP26:
                begin
                    dec.result.write_data = (request.current_word & JUMP_KEEP_MASK)
                                          | ({2'b00, value[31:2]} & JUMP_FIELD_MASK);
                end
                RELOC_HI16:
                begin
                    dec.action = ACT_QUEUE;
                end
                RELOC_LO16:
                begin
                    // own low-half write, held until the queue walk ends
                    dec.action            = ACT_WALK;
                    dec.result.write_data = {request.current_word[31:16], value[15:0]};
                end
                default:
                begin
                    dec.result.status = STATUS_BAD_TYPE;
                end
            endcase
        end
    end

endmodule

[design/mips_reloc_patch_engine_unit.sv]
// mips_reloc_patch_engine_unit: top level of the MIPS RELA relocation patch engine.
// Depends on mrpe_pkg, mrpe_decode and mrpe_ram.
//
//  channel   | handshake              | payload
//  ----------+------------------------+-------------------
//  request   | start, busy            | request (request_t)
//  result    | result_valid (strobe)  | result (result_t)
//
// Section start, HI16 and single-result records are handled while idle; busy stays low.
// A LO16 record walks the pending queue through the one read port of the queue RAM:
// busy goes high once it is accepted and stays high until its own result is emitted.
// Each result shows for exactly one cycle; the receiver cannot stall.
// Reset clears the queue count and control state; the queue RAM itself needs no clear.
module mips_reloc_patch_engine_unit
    import mrpe_pkg::*;
#(
    parameter int QUEUE_DEPTH = 32
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  request_t request,
    output logic     result_valid,
    output result_t  result
);

    localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_WALK = 2'b10
    } state_t;

    state_t      state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] rd_idx_reg, rd_idx_next;
    logic [CW-1:0] wr_idx_reg, wr_idx_next;
    logic        rd_vld_reg, rd_vld_next;
    logic        result_valid_reg, result_valid_next;
    result_t     result_reg, result_next;
    result_t     own_reg, own_next;
    logic [31:0] value_reg, value_next;
    logic [15:0] hi_reg, hi_next;

    decode_t     dec;
    logic        ram_we;
    logic [IW-1:0] ram_waddr;
    entry_t      ram_wdata;
    entry_t      ram_rdata;

    mrpe_decode u_decode (
        .request (request),
        .dec     (dec)
    );

    mrpe_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (rd_idx_reg[IW-1:0]),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next        = state_reg;
        count_next        = count_reg;
        rd_idx_next       = rd_idx_reg;
        wr_idx_next       = wr_idx_reg;
        rd_vld_next       = rd_vld_reg;
        result_valid_next = 1'b0;
        result_next       = result_reg;
        own_next          = own_reg;
        value_next        = value_reg;
        hi_next           = hi_reg;
        ram_we            = 1'b0;
        ram_waddr         = count_reg[IW-1:0];
        ram_wdata         = dec.entry;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    unique case (dec.action)
                        ACT_CLEAR:
                        begin
                            count_next = '0;
                        end
                        ACT_EMIT:
                        begin
                            result_valid_next = 1'b1;
                            result_next       = dec.result;
                        end
                        ACT_QUEUE:
                        begin
                            // drop the item when the queue is full
                            if (count_reg < CW'(QUEUE_DEPTH))
                            begin
                                ram_we     = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        ACT_WALK:
                        begin
                            state_next  = ST_WALK;
                            own_next    = dec.result;
                            value_next  = dec.entry.value;
                            hi_next     = dec.hi;
                            rd_idx_next = '0;
                            wr_idx_next = '0;
                            rd_vld_next = 1'b0;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_WALK:
            begin
                // issue the next read while the previous entry is evaluated
                if (rd_idx_reg < count_reg)
                begin
                    rd_idx_next = rd_idx_reg + 1'b1;
                    rd_vld_next = 1'b1;
                end
                else
                begin
                    rd_vld_next = 1'b0;
                end
                if (rd_vld_reg)
                begin
                    if (ram_rdata.value == value_reg)
                    begin
                        result_valid_next         = 1'b1;
                        result_next.write_address = ram_rdata.address;
                        result_next.write_data    = {ram_rdata.word[31:16], hi_reg};
                        result_next.status        = STATUS_PATCH;
                        result_next.last          = 1'b0;
                    end
                    else
                    begin
                        // compact: write index never passes the read index
                        ram_we      = 1'b1;
                        ram_waddr   = wr_idx_reg[IW-1:0];
                        ram_wdata   = ram_rdata;
                        wr_idx_next = wr_idx_reg + 1'b1;
                    end
                end
                else if (rd_idx_reg >= count_reg)
                begin
                    result_valid_next = 1'b1;
                    result_next       = own_reg;
                    count_next        = wr_idx_reg;
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            count_reg        <= '0;
            rd_idx_reg       <= '0;
            wr_idx_reg       <= '0;
            rd_vld_reg       <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            count_reg        <= count_next;
            rd_idx_reg       <= rd_idx_next;
            wr_idx_reg       <= wr_idx_next;
            rd_vld_reg       <= rd_vld_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        own_reg    <= own_next;
        value_reg  <= value_next;
        hi_reg     <= hi_next;
    end

    assign busy         = (state_reg == ST_WALK);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

[design/mrpe_checker.sv]
// mrpe_checker: port-level assertions for the relocation patch engine, bound to the top.
// Depends on mrpe_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mrpe_checker
    import mrpe_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     start,
    input logic     busy,
    input request_t request,
    input logic     result_valid,
    input result_t  result
);

    logic lo16_accept;
    logic word32_accept;

    assign lo16_accept   = start && !busy && !request.req_type && !request.symbol_missing
                        && (request.reloc_type == RELOC_LO16);
    assign word32_accept = start && !busy && !request.req_type && !request.symbol_missing
                        && (request.reloc_type == RELOC_WORD32);

    `MRPE_ASSERT_NXT(a_lo16_walks, lo16_accept, busy)
    `MRPE_ASSERT_IMP(a_walk_ends_with_last, $fell(busy), result_valid && result.last)
    `MRPE_ASSERT_IMP(a_queued_patch_in_walk, result_valid && !result.last, busy)
    `MRPE_ASSERT_NXT(a_word32_single, word32_accept,
                     result_valid && result.last && (result.status == STATUS_PATCH))
    `MRPE_ASSERT_IMP(a_error_is_last, result_valid && (result.status != STATUS_PATCH),
                     result.last)

endmodule

bind mips_reloc_patch_engine_unit mrpe_checker u_mrpe_checker (.*);

[tb/tb_mips_reloc_patch_engine_unit.sv]
// tb_mips_reloc_patch_engine_unit: self-checking testbench of the relocation patch engine.
// Depends on mrpe_pkg and mips_reloc_patch_engine_unit; the pending HI16 queue is
// predicted in the bench and every result is compared with it.
module tb_mips_reloc_patch_engine_unit;
    import mrpe_pkg::*;

    localparam int QUEUE_DEPTH = 32;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 40;
    localparam int ITEM_TARGET = 270;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     start = 1'b0;
    logic     busy;
    request_t request = '0;
    logic     result_valid;
    result_t  result;

    // items waiting to be driven, and results the block still owes
    request_t reloc_stream[$];
    result_t  patch_writes[$];

    // bench copy of the pending HI16 queue
    logic [31:0] hi_addr[QUEUE_DEPTH];
    logic [31:0] hi_val[QUEUE_DEPTH];
    logic [31:0] hi_word[QUEUE_DEPTH];
    int          hi_count = 0;

    logic    req_taken = 1'b0;
    result_t due;
    int      cycles = 0;
    int      items_sent = 0;
    int      items_taken = 0;
    int      results_seen = 0;
    int      mismatches = 0;
    int      hi_dropped = 0;
    int      max_burst = 0;
    int      full_runs = 0;

    mips_reloc_patch_engine_unit #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .request(request),
        .result_valid(result_valid),
        .result(result)
    );

    always #5 clk = ~clk;

    task automatic predict_patches(input request_t r);
        logic [31:0] v;
        logic [31:0] slo;
        logic [31:0] hi;
        int          keep;
        int          burst;
        v = r.symbol_value + r.addend;
        slo = {{16{v[15]}}, v[15:0]};
        burst = 0;
        if (r.req_type)
        begin
            hi_count = 0;
        end
        else if (r.symbol_missing)
        begin
            patch_writes.push_back('{r.target_address, 32'h0, STATUS_UNRESOLVED, 1'b1});
            burst = 1;
        end
        else if (r.reloc_type == RELOC_WORD32)
        begin
            patch_writes.push_back('{r.target_address, r.current_word + v, STATUS_PATCH, 1'b1});
            burst = 1;
        end
        else if (r.reloc_type == RELOC_JUMP26)
        begin
            patch_writes.push_back('{r.target_address,
                (r.current_word & JUMP_KEEP_MASK) | ((v >> 2) & JUMP_FIELD_MASK),
                STATUS_PATCH, 1'b1});
            burst = 1;
        end
        else if (r.reloc_type == RELOC_HI16)
        begin
            // drop silently once the queue is full
            if (hi_count < QUEUE_DEPTH)
            begin
                hi_addr[hi_count] = r.target_address;
                hi_val[hi_count] = v;
                hi_word[hi_count] = r.current_word;
                hi_count++;
            end
            else
                hi_dropped++;
        end
        else if (r.reloc_type == RELOC_LO16)
        begin
            keep = 0;
            for (int i = 0; i < hi_count; i++)
            begin
                if (hi_val[i] == v)
                begin
                    hi = hi_val[i] - slo;
                    patch_writes.push_back('{hi_addr[i], {hi_word[i][31:16], hi[31:16]},
                        STATUS_PATCH, 1'b0});
                    burst++;
                end
                else
                begin
                    hi_addr[keep] = hi_addr[i];
                    hi_val[keep] = hi_val[i];
                    hi_word[keep] = hi_word[i];
                    keep++;
                end
            end
            hi_count = keep;
            patch_writes.push_back('{r.target_address, {r.current_word[31:16], v[15:0]},
                STATUS_PATCH, 1'b1});
            burst++;
        end
        else
        begin
            patch_writes.push_back('{r.target_address, 32'h0, STATUS_BAD_TYPE, 1'b1});
            burst = 1;
        end
        if (burst > max_burst)
            max_burst = burst;
    endtask

    task automatic flag_field(input string fname, input logic [31:0] want,
                              input logic [31:0] got);
        $display("%0t: %s mismatch, expected %h, actual %h", $time, fname, want, got);
        mismatches++;
    endtask

    task automatic push_raw(input logic req, input logic [7:0] kind, input logic [31:0] addr,
                            input logic [31:0] sym, input logic [31:0] add,
                            input logic [31:0] word, input logic miss);
        reloc_stream.push_back('{req, kind, addr, sym, add, word, miss});
    endtask

    // record whose symbol plus addend lands on v
    task automatic push_rec(input logic [7:0] kind, input logic [31:0] v, input logic miss);
        logic [31:0] sym;
        sym = ($urandom_range(7) == 0) ? 32'h0 : $urandom;
        push_raw(1'b0, kind, $urandom, sym, v - sym, $urandom, miss);
    endtask

    task automatic push_section();
        push_raw(1'b1, 8'($urandom), $urandom, $urandom, $urandom, $urandom, 1'($urandom));
    endtask

    task automatic push_noise();
        case ($urandom_range(5))
            0: push_rec(RELOC_WORD32, $urandom, 1'b0);
            1: push_rec(RELOC_JUMP26, $urandom, 1'b0);
            2: push_rec(8'($urandom), $urandom, 1'b0);
            3: push_rec(8'($urandom), $urandom, 1'b1);
            4: push_section();
            default: push_rec(RELOC_LO16, $urandom, 1'b0);
        endcase
    endtask

    // a run of HI16 records and the LO16 records that should pair with them
    task automatic push_group();
        logic [31:0] pool[3];
        int          n_hi;
        int          n_lo;
        for (int j = 0; j < 3; j++)
            pool[j] = $urandom;
        n_hi = $urandom_range(1, 6);
        n_lo = $urandom_range(1, 2);
        if ($urandom_range(4) == 0)
            push_section();
        for (int i = 0; i < n_hi; i++)
        begin
            if ($urandom_range(4) == 0)
                push_noise();
            push_rec(RELOC_HI16, pool[$urandom_range(2)], $urandom_range(15) == 0);
        end
        for (int i = 0; i < n_lo; i++)
            push_rec(RELOC_LO16, pool[$urandom_range(2)], $urandom_range(15) == 0);
    endtask

    // overfill the queue, then release it with one LO16
    task automatic push_full(input logic same);
        logic [31:0] v0;
        logic [31:0] v1;
        v0 = $urandom;
        v1 = $urandom;
        push_section();
        for (int i = 0; i < QUEUE_DEPTH + 2; i++)
            push_rec(RELOC_HI16, (same || $urandom_range(1)) ? v0 : v1, 1'b0);
        push_rec(RELOC_LO16, v0, 1'b0);
    endtask

    task automatic build_stream();
        push_raw(1'b1, 8'hFF, '1, '1, '1, '1, 1'b1);
        push_raw(1'b0, RELOC_WORD32, '0, '0, '0, '0, 1'b0);
        push_raw(1'b0, RELOC_WORD32, '1, '1, '1, '1, 1'b0);
        push_raw(1'b0, RELOC_JUMP26, '1, '1, '0, '1, 1'b0);
        push_rec(RELOC_JUMP26, $urandom, 1'b0);
        push_rec(8'd0, $urandom, 1'b0);
        push_rec(8'd1, $urandom, 1'b0);
        push_rec(8'd3, $urandom, 1'b0);
        push_rec(8'd7, $urandom, 1'b0);
        push_rec(8'hFF, $urandom, 1'b0);
        push_rec(RELOC_WORD32, $urandom, 1'b1);
        push_rec(RELOC_HI16, 32'h1234_8000, 1'b1);
        push_rec(8'hFF, $urandom, 1'b1);
        push_rec(RELOC_LO16, 32'h0000_8001, 1'b0);
        // two matches, compaction keeps the middle entry
        push_rec(RELOC_HI16, 32'h1234_8000, 1'b0);
        push_rec(RELOC_HI16, 32'h0000_7FFF, 1'b0);
        push_rec(RELOC_HI16, 32'h1234_8000, 1'b0);
        push_rec(RELOC_LO16, 32'h1234_8000, 1'b0);
        push_rec(RELOC_LO16, 32'h0000_7FFF, 1'b0);
        // a section start forgets the queued HI16
        push_rec(RELOC_HI16, 32'hABCD_0123, 1'b0);
        push_section();
        push_rec(RELOC_LO16, 32'hABCD_0123, 1'b0);
        push_rec(RELOC_HI16, 32'h0, 1'b0);
        push_rec(RELOC_LO16, 32'h0, 1'b0);
        push_rec(RELOC_HI16, 32'hFFFF_FFFF, 1'b0);
        push_rec(RELOC_LO16, 32'hFFFF_FFFF, 1'b0);

        while (reloc_stream.size() < ITEM_TARGET)
        begin
            if ((full_runs == 0 && reloc_stream.size() >= 70) ||
                (full_runs == 1 && reloc_stream.size() >= 170))
            begin
                push_full(full_runs == 0);
                full_runs++;
            end
            else if ($urandom_range(99) < 60)
                push_group();
            else
                push_noise();
        end
    endtask

    // driver: hold an item until it is taken, then load the next or idle
    always @(negedge clk)
    begin
        if (!rst_n)
            start <= 1'b0;
        else if (!start || req_taken)
        begin
            if (reloc_stream.size() != 0 &&
                ((items_sent >= 110 && items_sent < 170) || $urandom_range(99) >= 37))
            begin
                request <= reloc_stream.pop_front();
                start <= 1'b1;
                items_sent++;
            end
            else
                start <= 1'b0;
        end
    end

    // monitor: predict on acceptance first, then check the result strobe
    always @(posedge clk)
    begin
        req_taken <= start && !busy;
        if (rst_n)
        begin
            cycles++;
            if (start && !busy)
            begin
                predict_patches(request);
                items_taken++;
            end
            if (result_valid)
            begin
                results_seen++;
                if (patch_writes.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual %h %h %0d %0b",
                             $time, result.write_address, result.write_data,
                             result.status, result.last);
                    mismatches++;
                end
                else
                begin
                    due = patch_writes.pop_front();
                    if (result.write_address !== due.write_address)
                        flag_field("write_address", due.write_address, result.write_address);
                    if (result.write_data !== due.write_data)
                        flag_field("write_data", due.write_data, result.write_data);
                    if (result.status !== due.status)
                        flag_field("status", 32'(due.status), 32'(result.status));
                    if (result.last !== due.last)
                        flag_field("last", 32'(due.last), 32'(result.last));
                end
            end
            if (cycles > CYCLE_LIMIT)
            begin
                $display("%0t: timeout with %0d results outstanding", $time,
                         patch_writes.size());
                $display("status: fail");
                $finish;
            end
        end
    end

    initial
    begin
        build_stream();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        while (reloc_stream.size() != 0 || start)
            @(posedge clk);
        while (patch_writes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("summary: %0d items taken, %0d results checked, %0d mismatches",
                 items_taken, results_seen, mismatches);
        $display("summary: largest burst %0d results, %0d HI16 dropped on a full queue",
                 max_burst, hi_dropped);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
